/* src/local_binary_pattern_3x3_defines.svh */
// Assertion macros used by the RTL of the 3x3 local binary pattern block.
`ifndef LOCAL_BINARY_PATTERN_3X3_DEFINES_SVH
`define LOCAL_BINARY_PATTERN_3X3_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define LBP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lbp3_pkg.sv */
`default_nettype none

package lbp3_pkg;

	localparam int PIX_W      = 8;
	localparam int CODE_W     = 8;
	localparam int FW_BITS    = 11;
	localparam int FH_BITS    = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	typedef logic [PIX_W-1:0]      pixel_t;
	typedef logic [CODE_W-1:0]     code_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// register indexes on the configuration port
	localparam cfg_idx_t REG_FRAME_WIDTH  = 1'b0;
	localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

	// line memory entry: row two above in the upper byte, row above in the lower
	typedef struct packed {
		pixel_t two_above;
		pixel_t above;
	} line_entry_t;

endpackage

`default_nettype wire

/* src/local_binary_pattern_3x3.sv */
// Path: an accepted pixel beat is registered into stage 1, which may stall, then its code into the output register.
// Throughput: one pixel per cycle; the single line memory is read once and written
// once per cycle, and a write to the column being read is forwarded. in_ready drops
// only while a code sits in stage 1 and the output register is full with out_ready low.
// Reset: position counters clear, size registers go to 640 x 480, window clears.
// The line memory is not cleared; its contents before the first row are unknown.
`default_nettype none
`include "local_binary_pattern_3x3_defines.svh"

module local_binary_pattern_3x3
	import lbp3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	// pixel stream
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire pixel_t    pixel,
	input  wire logic      frame_start,
	// code stream
	output logic           out_valid,
	input  wire logic      out_ready,
	output code_t          lbp_code,
	output logic           row_end,
	output logic           frame_end,
	// configuration writes
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire cfg_idx_t  cfg_index,
	input  wire cfg_data_t cfg_data
);

	// column index, width holding MAX_WIDTH, and the same for rows
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = RW + 1;
	// compare widths wide enough for both the register and the limit
	localparam int EWW = (WW > FW_BITS) ? WW : FW_BITS;
	localparam int EHW = (HW > FH_BITS) ? HW : FH_BITS;
	localparam int W_RST = (640 > MAX_WIDTH)  ? MAX_WIDTH  : 640;
	localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	// ------------------------------------------------------------------
	// Size registers, held already clamped to 3..MAX
	// ------------------------------------------------------------------
	logic [WW-1:0]  w_q;
	logic [HW-1:0]  h_q;
	logic [EWW-1:0] fw_ext;
	logic [EHW-1:0] fh_ext;
	logic [WW-1:0]  w_clamp;
	logic [HW-1:0]  h_clamp;

	assign cfg_ready = 1'b1;
	assign fw_ext    = EWW'(cfg_data[FW_BITS-1:0]);
	assign fh_ext    = EHW'(cfg_data[FH_BITS-1:0]);

	always_comb begin
		priority if (fw_ext < EWW'(3)) begin
			w_clamp = WW'(3);
		end else if (fw_ext > EWW'(MAX_WIDTH)) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = fw_ext[WW-1:0];
		end
		priority if (fh_ext < EHW'(3)) begin
			h_clamp = HW'(3);
		end else if (fh_ext > EHW'(MAX_HEIGHT)) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = fh_ext[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RST);
			h_q <= HW'(H_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  w_q <= w_clamp;
				REG_FRAME_HEIGHT: h_q <= h_clamp;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: place the incoming beat in the frame, issue the line read
	// ------------------------------------------------------------------
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_st;
	logic [RW-1:0] row_st;
	logic [CW-1:0] c0;
	logic [RW-1:0] r0;
	logic [HW-1:0] r_inc;
	logic [WW-1:0] c_inc0;
	logic [HW-1:0] r_inc0;
	logic [CW-1:0] col_next;
	logic [RW-1:0] row_next;
	logic          accept;

	always_comb begin
		// frame_start forces row 0, column 0
		col_st = frame_start ? '0 : col_q;
		row_st = frame_start ? '0 : row_q;
		// a column past a shrunken width starts the next row
		r_inc = {1'b0, row_st};
		c0    = col_st;
		if ({1'b0, col_st} >= w_q) begin
			c0    = '0;
			r_inc = {1'b0, row_st} + HW'(1);
		end
		// a row past the height wraps to row 0
		r0 = (r_inc >= h_q) ? '0 : r_inc[RW-1:0];

		// position of the beat after this one
		c_inc0   = {1'b0, c0} + WW'(1);
		r_inc0   = {1'b0, r0} + HW'(1);
		col_next = c_inc0[CW-1:0];
		row_next = r0;
		if (c_inc0 >= w_q) begin
			col_next = '0;
			row_next = (r_inc0 >= h_q) ? '0 : r_inc0[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: read data arrives, form the code, write the column back
	// ------------------------------------------------------------------
	logic          s1_valid_q;
	pixel_t        px_s1;
	logic [CW-1:0] col_s1;
	logic          res_s1;
	logic          row_end_s1;
	logic          frame_end_s1;
	logic          s1_adv;
	logic          s1_fire;

	// stage 1 moves on unless it holds a code and the output register is full
	assign s1_adv   = !res_s1 || !out_valid || out_ready;
	assign s1_fire  = s1_valid_q && s1_adv;
	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pixel;
			col_s1       <= c0;
			res_s1       <= (r0 >= RW'(2)) && (c0 >= CW'(2));
			row_end_s1   <= ({1'b0, c0} == w_q - WW'(1));
			frame_end_s1 <= ({1'b0, c0} == w_q - WW'(1)) && ({1'b0, r0} == h_q - HW'(1));
		end
	end

	// Line memory: one entry per column, holding both rows above
	line_entry_t   line_mem [MAX_WIDTH];
	line_entry_t   line_rd_q;
	line_entry_t   wr_entry;
	line_entry_t   fwd_data_q;
	logic          fwd_q;
	logic [CW-1:0] rd_addr;
	line_entry_t   rows_above;

	// re-read the held column while stage 1 stalls, else read the new one
	assign rd_addr = (s1_valid_q && !s1_adv) ? col_s1 : c0;

	// the column just read becomes the upper row, the pixel the row above
	assign rows_above = fwd_q ? fwd_data_q : line_rd_q;
	assign wr_entry   = '{two_above: rows_above.above, above: px_s1};

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			line_mem[col_s1] <= wr_entry;
		end
		line_rd_q <= line_mem[rd_addr];
	end

	// a write landing on the column read in the same cycle is forwarded;
	// only a frame_start right after a beat at column 0 can cause it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= s1_fire && accept && (c0 == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fwd_data_q <= wr_entry;
		end
	end

	// Window of the two previous columns: 0,1 upper row, 2,3 middle, 4,5 lower
	pixel_t win_q [6];
	code_t  code_s1;
	pixel_t ctr;

	assign ctr = win_q[3];

	always_comb begin
		code_s1[7] = win_q[0] > ctr;
		code_s1[6] = win_q[1] > ctr;
		code_s1[5] = rows_above.two_above > ctr;
		code_s1[4] = rows_above.above > ctr;
		code_s1[3] = px_s1 > ctr;
		code_s1[2] = win_q[5] > ctr;
		code_s1[1] = win_q[4] > ctr;
		code_s1[0] = win_q[2] > ctr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_fire) begin
			// advance the window one column
			win_q[0] <= win_q[1];
			win_q[1] <= rows_above.two_above;
			win_q[2] <= win_q[3];
			win_q[3] <= rows_above.above;
			win_q[4] <= win_q[5];
			win_q[5] <= px_s1;
		end
	end

	// ------------------------------------------------------------------
	// Output register: holds a code beat until it is taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_fire && res_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_s1) begin
			lbp_code  <= code_s1;
			row_end   <= row_end_s1;
			frame_end <= frame_end_s1;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`LBP_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid_q,
		"accepted beat did not reach stage 1")
	`LBP_ASSERT_NEXT(a_stall_holds_s1, s1_valid_q && !s1_adv,
		s1_valid_q && $stable(col_s1) && $stable(px_s1),
		"stalled stage 1 lost its beat")
	`LBP_ASSERT_NOW(a_fwd_after_write, fwd_q, $past(s1_fire) && $past(accept),
		"forwarding without a write and read of the same column")
	`LBP_ASSERT_NOW(a_frame_end_row_end, out_valid && frame_end, row_end,
		"frame end code not marked as row end")

endmodule

`default_nettype wire

/* tb/sv/local_binary_pattern_3x3_tb.sv */
`default_nettype none

module local_binary_pattern_3x3_tb
	import lbp3_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LINE_MAX       = 1024;
	localparam int          ROWS_MAX       = 4096;
	localparam int          WATCHDOG_LIMIT = 2000;
	// pixel beats for the whole run; the random test tops the count up to this
	localparam int unsigned ITEM_TARGET    = 550;
	// extra wait after the last code has left, before a register write
	localparam int          SETTLE_CYCLES  = 4;
	localparam pixel_t      PIX_LOW        = 8'h00;
	localparam pixel_t      PIX_HIGH       = 8'hFF;

	// one expected or observed code beat
	typedef struct packed {
		code_t code;
		logic  row_end;
		logic  frame_end;
	} lbp_result_t;

	logic      clk;
	logic      arst_n      = 1'b0;
	logic      in_valid    = 1'b0;
	logic      in_ready;
	pixel_t    pixel       = '0;
	logic      frame_start = 1'b0;
	logic      out_valid;
	logic      out_ready   = 1'b0;
	code_t     lbp_code;
	logic      row_end;
	logic      frame_end;
	logic      cfg_valid   = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index   = REG_FRAME_WIDTH;
	cfg_data_t cfg_data    = '0;

	// shadow of the size registers, at their reset values
	logic [FW_BITS-1:0] width_reg  = 11'd640;
	logic [FH_BITS-1:0] height_reg = 13'd480;

	// predictor state: two previous rows, the 3x3 window history and the raster position
	pixel_t      line_one [0:LINE_MAX-1];
	pixel_t      line_two [0:LINE_MAX-1];
	pixel_t      win_px [0:5];
	int unsigned next_col = 0;
	int unsigned next_row = 0;

	lbp_result_t expected_codes [$];

	bit          calm_phase    = 1'b0;
	int unsigned ready_hold    = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned mismatches    = 0;
	int unsigned codes_checked = 0;
	int unsigned items_sent    = 0;
	int unsigned regs_written  = 0;

	local_binary_pattern_3x3 DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.lbp_code   (lbp_code),
		.row_end    (row_end),
		.frame_end  (frame_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Saturate a size register to the range the block actually uses.
	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int unsigned eff_width();
		return clamp_dim(width_reg, LINE_MAX);
	endfunction

	function automatic int unsigned eff_height();
		return clamp_dim(height_reg, ROWS_MAX);
	endfunction

	// Advance the raster position by one accepted pixel and queue the code it completes.
	// The window holds columns c-2 and c-1 of the three rows: entries 0,1 two rows up,
	// 2,3 one row up (entry 3 is the centre), 4,5 the current row.
	function automatic void predict_code(pixel_t px, logic start);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		pixel_t      up2;
		pixel_t      up1;
		pixel_t      ctr;
		lbp_result_t res;
		w = eff_width();
		h = eff_height();
		if (start) begin
			next_col = 0;
			next_row = 0;
		end
		// a size that shrank under the current position pushes it to the next row
		if (next_col >= w) begin
			next_col = 0;
			next_row++;
		end
		if (next_row >= h)
			next_row = 0;
		c = next_col;
		r = next_row;
		up2 = line_two[c];
		up1 = line_one[c];
		// border pixels complete no neighbourhood
		if (r >= 2 && c >= 2) begin
			ctr = win_px[3];
			res.code = {win_px[0] > ctr, win_px[1] > ctr, up2 > ctr, up1 > ctr,
				px > ctr, win_px[5] > ctr, win_px[4] > ctr, win_px[2] > ctr};
			res.row_end   = (c == w - 1);
			res.frame_end = (c == w - 1) && (r == h - 1);
			expected_codes.insert(expected_codes.size(), res);
		end
		win_px[0] = win_px[1];
		win_px[1] = up2;
		win_px[2] = win_px[3];
		win_px[3] = up1;
		win_px[4] = win_px[5];
		win_px[5] = px;
		line_two[c] = up1;
		line_one[c] = px;
		// the last pixel of a frame wraps to the top-left, so frames may run back to back
		next_col = c + 1;
		if (next_col >= w) begin
			next_col = 0;
			next_row = r + 1;
			if (next_row >= h)
				next_row = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Idle length: mostly none or short, now and then long; none at all in a calm phase.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm_phase || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Bias pixels towards ties and near-ties so the strict comparison is exercised.
	function automatic pixel_t pick_pixel();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return pixel_t'($urandom_range(0, 255));
		if (roll < 75)
			return pixel_t'($urandom_range(118, 121));
		if (roll < 88)
			return PIX_LOW;
		return PIX_HIGH;
	endfunction

	// Send one pixel beat. Valid stays high after acceptance so back-to-back beats
	// need no second assignment in the same step; whoever pauses drops it.
	task automatic send_pixel(input pixel_t px, input logic start);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		pixel       <= px;
		frame_start <= start;
		do @(posedge clk); while (!in_ready);
		predict_code(px, start);
		items_sent++;
	endtask

	// Drop valid, wait for every pending code, then let the pipeline empty out.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one size register while the block is idle.
	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FRAME_WIDTH)
			width_reg = value[FW_BITS-1:0];
		else
			height_reg = value[FH_BITS-1:0];
		regs_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stream whole frames at the current size, the first one marked with frame_start.
	// With noise on, a rare stray frame_start breaks a frame off part-way.
	// Stop early once the run has sent its share of pixel beats.
	task automatic send_frames(input int unsigned n_frames, input bit noisy);
		int unsigned total;
		logic        start;
		total = eff_width() * eff_height();
		for (int unsigned f = 0; f < n_frames && items_sent < ITEM_TARGET; f++) begin
			for (int unsigned i = 0; i < total && items_sent < ITEM_TARGET; i++) begin
				start = (f == 0 && i == 0);
				if (noisy && $urandom_range(0, 99) == 0)
					start = 1'b1;
				send_pixel(pick_pixel(), start);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset sizes are 640 x 480 and the position starts at the top-left without
	// frame_start: the first row completes no neighbourhood, so no code may appear.
	task automatic test_reset_sizes();
		calm_phase = 1'b1;
		for (int unsigned i = 0; i < 40; i++)
			send_pixel(pick_pixel(), 1'b0);
		calm_phase = 1'b0;
	endtask

	// Checkerboard of the two pixel extremes: dark centres see four brighter
	// edge neighbours, bright centres see none.
	task automatic test_checkerboard();
		write_reg(REG_FRAME_WIDTH, 13'd5);
		write_reg(REG_FRAME_HEIGHT, 13'd5);
		for (int unsigned r = 0; r < 5; r++)
			for (int unsigned c = 0; c < 5; c++)
				send_pixel(((r + c) % 2) ? PIX_HIGH : PIX_LOW, r == 0 && c == 0);
	endtask

	// Frames follow one another with no frame_start after the first.
	task automatic test_back_to_back();
		write_reg(REG_FRAME_WIDTH, 13'd4);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		send_frames(3, 1'b0);
	endtask

	// Out-of-range sizes saturate: a huge height clamps to the maximum, zero sizes
	// clamp to 3, and an all-ones width clamps to the widest line.
	task automatic test_size_limits();
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		for (int unsigned i = 0; i < 15; i++)
			send_pixel(pick_pixel(), i == 0);
		write_reg(REG_FRAME_WIDTH, 13'd0);
		write_reg(REG_FRAME_HEIGHT, 13'd0);
		// dark centre in a bright ring sets every bit, then the inverse with no restart
		for (int unsigned i = 0; i < 9; i++)
			send_pixel((i == 4) ? PIX_LOW : PIX_HIGH, i == 0);
		for (int unsigned i = 0; i < 9; i++)
			send_pixel((i == 4) ? PIX_HIGH : PIX_LOW, 1'b0);
		write_reg(REG_FRAME_WIDTH, 13'h1FFF);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		// the widest line keeps a dozen pixels in row 0; a narrow width then moves
		// the position to row 1, and row 2 gives codes only if the clamp held
		calm_phase = 1'b1;
		for (int unsigned i = 0; i < 12; i++)
			send_pixel(pick_pixel(), i == 0);
		calm_phase = 1'b0;
		write_reg(REG_FRAME_WIDTH, 13'd5);
		for (int unsigned i = 0; i < 10; i++)
			send_pixel(pick_pixel(), 1'b0);
	endtask

	// Shrink the sizes under the current position: a column past the new width
	// moves to the next row, a row past the new height wraps to the top.
	task automatic test_resize_midframe();
		write_reg(REG_FRAME_WIDTH, 13'd8);
		write_reg(REG_FRAME_HEIGHT, 13'd6);
		for (int unsigned i = 0; i < 3 * 8 + 5; i++)
			send_pixel(pick_pixel(), i == 0);
		write_reg(REG_FRAME_WIDTH, 13'd4);
		for (int unsigned i = 0; i < 6; i++)
			send_pixel(pick_pixel(), 1'b0);
		write_reg(REG_FRAME_HEIGHT, 13'd4);
		for (int unsigned i = 0; i < 2 + 3 * 4; i++)
			send_pixel(pick_pixel(), 1'b0);
	endtask

	// Random sizes, mostly small, each followed by a few whole frames with random
	// content, stray restarts and calm stretches now and then, until the run has
	// sent its share of pixel beats.
	task automatic test_random_frames();
		int unsigned w;
		while (items_sent < ITEM_TARGET) begin
			calm_phase = ($urandom_range(0, 3) == 0);
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			write_reg(REG_FRAME_WIDTH, cfg_data_t'(w));
			write_reg(REG_FRAME_HEIGHT, cfg_data_t'($urandom_range(3, 7)));
			send_frames($urandom_range(1, 3), 1'b1);
		end
		calm_phase = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Code side: random back-pressure, checking and the watchdog
	// ------------------------------------------------------------------

	// Toggle ready in runs: low runs follow the gap distribution, high runs stay short.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (calm_phase) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			out_ready  <= ~out_ready;
			ready_hold <= out_ready ? pick_gap() : $urandom_range(0, 12);
		end
	end

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// Compare every accepted code beat with the oldest prediction.
	always @(posedge clk) begin : check_codes
		lbp_result_t want;
		if (arst_n && out_valid && out_ready) begin
			codes_checked++;
			if (expected_codes.size() == 0) begin
				flag_error($sformatf("unexpected code %02h row_end %0b frame_end %0b",
					lbp_code, row_end, frame_end));
			end else begin
				want = expected_codes.pop_front();
				if (want.code !== lbp_code || want.row_end !== row_end
						|| want.frame_end !== frame_end)
					flag_error($sformatf(
						"code exp %02h got %02h, row_end exp %0b got %0b, frame_end exp %0b got %0b",
						want.code, lbp_code, want.row_end, row_end, want.frame_end, frame_end));
			end
		end
	end

	// End the run if no beat of any kind moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		for (int i = 0; i < 6; i++)
			win_px[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_sizes();
		test_checkerboard();
		test_back_to_back();
		test_size_limits();
		test_resize_midframe();
		test_random_frames();

		settle();
		$display("Sent %0d pixel beats and %0d register writes, checked %0d codes.",
			items_sent, regs_written, codes_checked);
		$display("Covered the reset position, checkerboard and back-to-back frames, clamped");
		$display("and shrunk sizes, and random frames up to 40 wide under random stalls.");
		if (mismatches == 0 && expected_codes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
+incdir+src
src/lbp3_pkg.sv
src/local_binary_pattern_3x3.sv
tb/sv/local_binary_pattern_3x3_tb.sv
